// File: hw/rtl/rskx_pkg.sv
// ----------------------------------------------------------------------------
// rskx_pkg: shared types and constants of the reduced keystream XOR block
// Transfer payload structs, register indexes and the word rotate helper.
// ----------------------------------------------------------------------------
package rskx_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 16;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD0   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD1   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD2   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD3   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_NONCE_WORD0 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_NONCE_WORD1 = 3'd5;

    localparam logic [WORD_W-1:0] FILL_WORD   = 32'hdeadbeef;
    localparam logic [WORD_W-1:0] NONCE0_RST  = 32'h12345678;
    localparam logic [WORD_W-1:0] NONCE1_RST  = 32'h9abcdef0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] s);
        rol32 = (v << s) | (v >> (6'd32 - {1'b0, s}));
    endfunction

endpackage

// File: hw/rtl/reduced_salsa_keystream_xor.sv
// ----------------------------------------------------------------------------
// reduced_salsa_keystream_xor: message byte XOR with a fixed 64-byte keystream
// Builds the keystream from key and nonce words by two passes of column
// quarter rounds, then XORs one message byte per cycle with it while the input is not stalled.
//
//   channel   direction  signals                                 payload
//   in        sink       i_in_valid, o_in_stall, i_in_data       t_in_item
//   out       source     o_out_valid, i_out_stall, o_out_data    t_out_item
//   cfg       sink       i_cfg_wr_en, i_cfg_addr, i_cfg_wdata    32-bit word
//
// After reset and after every register write the keystream is rebuilt in
// one load step and eight mix steps, all four columns at once.
// o_in_stall is high during the rebuild. Afterwards one byte per cycle is
// taken while o_in_stall is low; each result is registered. A skid register
// holds one result while the output is stalled, so outside a rebuild input
// stalls only when both output and skid registers are full.
// ----------------------------------------------------------------------------
module reduced_salsa_keystream_xor
    import rskx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [WORD_W-1:0]     i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam logic [1:0] MIX_B = 2'd0;
    localparam logic [1:0] MIX_C = 2'd1;
    localparam logic [1:0] MIX_D = 2'd2;
    localparam logic [1:0] MIX_A = 2'd3;
    localparam logic [3:0] STEP_LOAD = 4'd0;
    localparam logic [3:0] STEP_LAST = 4'd8;

    logic [WORD_W-1:0] r_key [4];
    logic [WORD_W-1:0] r_nonce [2];
    logic [WORD_W-1:0] r_words [NUM_WORDS];
    logic [WORD_W-1:0] n_words [NUM_WORDS];
    logic              r_building;
    logic [3:0]        r_step;
    logic [3:0]        step_m1;
    logic [5:0]        r_pos;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              r_skid_valid;
    t_out_item         r_skid;
    t_out_item         result;
    logic              cfg_hit;
    logic              in_fire;
    logic              out_free;
    logic [WORD_W-1:0] sel_word;

    assign step_m1 = r_step - 4'd1;

    always_comb begin
        n_words = r_words;
        if (r_step == STEP_LOAD) begin
            for (int i = 0; i < 4; i++) begin
                n_words[i] = r_key[i];
            end
            n_words[4] = r_nonce[0];
            n_words[5] = r_nonce[1];
            for (int i = 6; i < NUM_WORDS; i++) begin
                n_words[i] = FILL_WORD;
            end
        end else begin
            for (int c = 0; c < 4; c++) begin
                case (step_m1[1:0])
                    MIX_B: n_words[c+4] = r_words[c+4]
                        ^ rol32(r_words[c] + r_words[c+12], 5'd7);
                    MIX_C: n_words[c+8] = r_words[c+8]
                        ^ rol32(r_words[c+4] + r_words[c], 5'd9);
                    MIX_D: n_words[c+12] = r_words[c+12]
                        ^ rol32(r_words[c+8] + r_words[c+4], 5'd13);
                    MIX_A: n_words[c] = r_words[c]
                        ^ rol32(r_words[c+12] + r_words[c+8], 5'd18);
                endcase
            end
        end
    end

    always_comb begin
        cfg_hit = 1'b0;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr) inside
                CFG_KEY_WORD0, CFG_KEY_WORD1, CFG_KEY_WORD2, CFG_KEY_WORD3,
                CFG_NONCE_WORD0, CFG_NONCE_WORD1: cfg_hit = 1'b1;
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]   <= '0;
            r_key[1]   <= '0;
            r_key[2]   <= '0;
            r_key[3]   <= '0;
            r_nonce[0] <= NONCE0_RST;
            r_nonce[1] <= NONCE1_RST;
            r_building <= 1'b1;
            r_step     <= STEP_LOAD;
        end else begin
            if (cfg_hit) begin
                if (i_cfg_addr == CFG_NONCE_WORD0) begin
                    r_nonce[0] <= i_cfg_wdata;
                end else if (i_cfg_addr == CFG_NONCE_WORD1) begin
                    r_nonce[1] <= i_cfg_wdata;
                end else begin
                    r_key[i_cfg_addr[1:0]] <= i_cfg_wdata;
                end
                r_building <= 1'b1;
                r_step     <= STEP_LOAD;
            end else if (r_building) begin
                r_step <= r_step + 4'd1;
                if (r_step == STEP_LAST) begin
                    r_building <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_building) begin
            r_words <= n_words;
        end
    end

    assign o_in_stall = r_building || r_skid_valid;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign sel_word        = r_words[r_pos[5:2]];
    assign result.out_byte = i_in_data.data_byte
                             ^ sel_word[{r_pos[1:0], 3'b000} +: 8];
    assign result.out_last = i_in_data.end_of_message;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_pos <= i_in_data.end_of_message ? 6'd0 : r_pos + 6'd1;
            end
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (in_fire) begin
                    r_out       <= result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_fire) begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
